// ===== rtl/mpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_pkg: moon phase calculator shared types and constants
// Angle constants are turn fractions, 2^64 units per turn.
// ----------------------------------------------------------------------------
package mpc_pkg;

	localparam int unsigned TAYLOR_N  = 6;
	localparam int unsigned LANES     = 8;   // sun g, sun 2g, six moon terms
	localparam int unsigned MOON_N    = 6;
	localparam int unsigned RMUL_LAT  = 3;
	localparam int unsigned SINE_LAT  = 5 + 3 * TAYLOR_N;
	localparam int unsigned PIPE_LAT  = RMUL_LAT + 2 * SINE_LAT + 9;

	localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
	localparam logic [31:0] PI_Q30    = 32'd3373259426;
	localparam logic [30:0] WIN_RESET = 31'd157200570;

	localparam int unsigned TAYLOR_DIV [TAYLOR_N] = '{156, 110, 72, 42, 20, 6};

	// sun
	localparam logic [63:0] SUN_G_BASE = 64'((128'd357528 << 64) / 128'd360000);
	localparam logic [63:0] SUN_G_RATE = 64'((128'd9856003 << 64) / 128'd3600000000);
	localparam logic [63:0] SUN_L_BASE = 64'((128'd280460 << 64) / 128'd360000);
	localparam logic [63:0] SUN_L_RATE = 64'((128'd9856474 << 64) / 128'd3600000000);

	// moon linear term
	localparam logic [63:0] MOON_L_BASE = 64'((128'd21832 << 64) / 128'd36000);
	localparam logic [63:0] MOON_L_RATE = 64'((128'd481267883 << 64) / 128'd13149000000);

	localparam logic [63:0] MOON_BASE [MOON_N] = '{
		64'((128'd1349 << 64) / 128'd3600),
		64'((128'd2592 << 64) / 128'd3600),
		64'((128'd2357 << 64) / 128'd3600),
		64'((128'd2699 << 64) / 128'd3600),
		64'((128'd3575 << 64) / 128'd3600),
		64'((128'd1866 << 64) / 128'd3600)
	};
	localparam logic [63:0] MOON_RATE [MOON_N] = '{
		64'((128'd47719885 << 64) / 128'd1314900000),
		64'((128'd41333538 << 64) / 128'd1314900000),
		64'((128'd89053423 << 64) / 128'd1314900000),
		64'((128'd95439770 << 64) / 128'd1314900000),
		64'((128'd3599905 << 64) / 128'd1314900000),
		64'((128'd96640405 << 64) / 128'd1314900000)
	};
	localparam bit MOON_RATE_NEG [MOON_N] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

	// amplitude of each sine lane, turn fraction >> 30
	localparam logic [31:0] LANE_AMP [LANES] = '{
		32'(((128'd1915 << 64) / 128'd360000) >> 30),
		32'(((128'd20 << 64) / 128'd360000) >> 30),
		32'(((128'd629 << 64) / 128'd36000) >> 30),
		32'(((128'd127 << 64) / 128'd36000) >> 30),
		32'(((128'd66 << 64) / 128'd36000) >> 30),
		32'(((128'd21 << 64) / 128'd36000) >> 30),
		32'(((128'd19 << 64) / 128'd36000) >> 30),
		32'(((128'd11 << 64) / 128'd36000) >> 30)
	};
	localparam bit LANE_AMP_NEG [LANES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

	typedef enum logic [2:0] {
		KIND_NEW       = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_FIRST_Q   = 3'd2,
		KIND_LAST_Q    = 3'd3,
		KIND_WAX_GIB   = 3'd4,
		KIND_WAX_CRES  = 3'd5,
		KIND_WANE_CRES = 3'd6,
		KIND_WANE_GIB  = 3'd7
	} phase_kind_t;

	// word handed from one Taylor cell to the next
	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic [30:0] t;
		logic        neg;
	} sin_cell_t;

	typedef struct packed {
		logic [31:0] sun;
		logic [31:0] moon;
		logic [31:0] phase;
		logic [6:0]  pct;
		phase_kind_t kind;
	} result_t;

endpackage

// ===== rtl/mpc_rate_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_rate_mul: constant rate times time magnitude
// 64 x 32 product in two 32 x 32 halves, shifted by the time fraction bits,
// sign applied last. Three stages.
// ----------------------------------------------------------------------------
module mpc_rate_mul #(
	parameter int          TIME_FRACTION_BITS = 16,
	parameter logic [63:0] RATE               = 64'd0,
	parameter bit          NEG                = 1'b0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] mag,
	input  logic        neg,
	output logic [63:0] prod
);

	logic [63:0] lo_s1, hi_s1;
	logic        neg_s1;
	logic [95:0] sum;
	logic [63:0] res_s2;
	logic        flip_s2;
	logic [63:0] res_s3;

	assign sum = {hi_s1, 32'd0} + {32'd0, lo_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= 64'(RATE[31:0]) * 64'(mag);
			hi_s1   <= 64'(RATE[63:32]) * 64'(mag);
			neg_s1  <= neg;
			res_s2  <= sum[TIME_FRACTION_BITS +: 64];
			flip_s2 <= neg_s1 ^ NEG;
			res_s3  <= flip_s2 ? (64'd0 - res_s2) : res_s2;
		end
	end

	assign prod = res_s3;

endmodule

// ===== rtl/mpc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_cell: one Taylor step of the sine chain
// t' = 2^30 - ((x2 * t) >> 30) / K. Division by reciprocal plus one
// correction. Three stages.
// ----------------------------------------------------------------------------
module mpc_cell import mpc_pkg::*; #(
	parameter int unsigned K = 6
) (
	input  logic      clk,
	input  logic      en,
	input  sin_cell_t din,
	output sin_cell_t dout
);

	localparam logic [29:0] RECIP = 30'((64'd1 << 32) / 64'(K));

	sin_cell_t   d_s1, d_s2, d_s3, nxt;
	logic [62:0] p1;
	logic [61:0] p2;
	logic [31:0] v_s1, v_s2;
	logic [29:0] q0_s2, q;
	logic [39:0] qk, r;

	assign p1 = 63'(din.x2) * 63'(din.t);
	assign p2 = 62'(v_s1) * 62'(RECIP);

	always_comb begin
		qk = 40'(q0_s2) * 40'(K);
		r  = 40'(v_s2) - qk;
		q  = q0_s2 + 30'(r >= 40'(K));
		nxt   = d_s2;
		nxt.t = 31'(Q30_ONE) - 31'(q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= din;
			v_s1  <= p1[61:30];
			d_s2  <= d_s1;
			v_s2  <= v_s1;
			q0_s2 <= p2[61:32];
			d_s3  <= nxt;
		end
	end

	assign dout = d_s3;

endmodule

// ===== rtl/mpc_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_sine: Q30 sine of a 64-bit turn fraction
// Quarter-turn fold, scale to radians, square, a row of Taylor cells,
// final product and clamp. Magnitude and sign out, SINE_LAT stages.
// ----------------------------------------------------------------------------
module mpc_sine import mpc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] angle,
	output logic [30:0] mag,
	output logic        neg
);

	logic [62:0] ff;
	logic [31:0] fs_s1;
	logic        neg_s1, neg_s2, neg_s4, neg_s5;
	logic [63:0] px;
	logic [30:0] x_s2;
	logic [61:0] pxx, ps;
	logic [31:0] s_s4;
	logic [30:0] mag_s5;
	sin_cell_t   head_s3;
	sin_cell_t   link [TAYLOR_N+1];

	assign ff  = angle[62] ? ((63'd1 << 62) - {1'b0, angle[61:0]}) : {1'b0, angle[61:0]};
	assign px  = 64'(fs_s1) * 64'(PI_Q30);
	assign pxx = 62'(x_s2) * 62'(x_s2);
	assign ps  = 62'(link[TAYLOR_N].x) * 62'(link[TAYLOR_N].t);

	always_ff @(posedge clk) begin
		if (en) begin
			fs_s1       <= ff[62:31];
			neg_s1      <= angle[63];
			x_s2        <= px[62:32];
			neg_s2      <= neg_s1;
			head_s3.x   <= x_s2;
			head_s3.x2  <= pxx[61:30];
			head_s3.t   <= 31'(Q30_ONE);
			head_s3.neg <= neg_s2;
			s_s4        <= ps[61:30];
			neg_s4      <= link[TAYLOR_N].neg;
			mag_s5      <= (s_s4 > Q30_ONE) ? 31'(Q30_ONE) : s_s4[30:0];
			neg_s5      <= neg_s4;
		end
	end

	assign link[0] = head_s3;

	for (genvar i = 0; i < TAYLOR_N; i++) begin : g_cell
		mpc_cell #(.K(TAYLOR_DIV[i])) u_cell (
			.clk (clk),
			.en  (en),
			.din (link[i]),
			.dout(link[i+1])
		);
	end

	assign mag = mag_s5;
	assign neg = neg_s5;

endmodule

// ===== rtl/moon_phase_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moon_phase_calculator: low-precision almanac moon phase
// Sun and moon ecliptic longitudes, phase angle, percent lit and phase
// class from a fixed-point day count after J2000.0.
// ----------------------------------------------------------------------------
//
//  channel | signals                                 | handshake
//  --------+-----------------------------------------+-----------------------
//  in      | days_after_epoch                        | in_valid / in_ready
//  out     | sun_longitude, moon_longitude,          | out_valid / out_ready
//          | phase_angle, percent_lit, phase_kind    |
//  cfg     | cfg_wdata (phase_window)                | cfg_we, no wait
//
//  One word per cycle sustained unless the output buffer is full and stalled;
//  the two sine lanes of six Taylor cells (23 stages each) lie in series.
//  Reset clears the valid line, the output buffer and sets phase_window
//  to its default. Every stage moves on a common enable; a two-word output
//  buffer takes finished words, so a stalled output stops intake only once
//  both entries are full.
// ----------------------------------------------------------------------------
module moon_phase_calculator import mpc_pkg::*; #(
	parameter int ANGLE_BITS         = 32,
	parameter int TIME_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] days_after_epoch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sun_longitude,
	output logic signed [31:0] moon_longitude,
	output logic signed [31:0] phase_angle,
	output logic [6:0]         percent_lit,
	output logic [2:0]         phase_kind
);

	localparam logic [63:0] ANGLE_MASK = ~64'd0 << (64 - ANGLE_BITS);
	localparam logic signed [33:0] HALF  = 34'sh0_8000_0000;
	localparam logic signed [33:0] QUART = 34'sh0_4000_0000;

	// control
	logic                en, push, pop;
	logic [1:0]          cnt_q;
	logic [PIPE_LAT-1:0] vld_q;
	logic [30:0]         phase_window_q;

	// time magnitude
	logic [31:0] mag_s1;
	logic        neg_s1;

	// rate products (stage 4)
	logic [63:0] rg, rl, rm;
	logic [63:0] rr [MOON_N];

	// sine arguments (stage 5)
	logic [63:0] g;
	logic [63:0] arg_s5 [LANES];
	logic [63:0] sunl_s5, moonl_s5;
	logic [30:0] smag [LANES];
	logic        sneg [LANES];
	logic [63:0] sunl_dly_q  [SINE_LAT];
	logic [63:0] moonl_dly_q [SINE_LAT];

	// sums
	logic [63:0] term_s29 [LANES];
	logic [63:0] sunl_s29, moonl_s29;
	logic [63:0] sa_s30, sb_s30, ma_s30, mb_s30, mc_s30, md_s30;
	logic [63:0] sun_s31, mab_s31, mcd_s31;
	logic [63:0] sun_s32, moon_s32;
	logic [63:0] ph_s33;
	logic [31:0] sun32_s33, moon32_s33;
	logic [63:0] cos_arg;
	logic [30:0] cmag;
	logic        cneg;
	logic [31:0] sun_dly_q [SINE_LAT];
	logic [31:0] moon_dly_q [SINE_LAT];
	logic [31:0] ph_dly_q [SINE_LAT];

	// classification
	logic signed [33:0] ps, pa1;
	logic [33:0]        a0, a1, a2, a3;
	logic [31:0]        c_s57;
	logic [33:0]        a0_s57, a1_s57, a2_s57, a3_s57;
	logic               gtq_s57, gt0_s57, gtmq_s57;
	logic [31:0]        sun_s57, moon_s57, ph_s57;
	logic [33:0]        w;
	logic [37:0]        pct_full;
	phase_kind_t        kind;
	result_t            res_s58, e0_q, e1_q;

	// ---------------- flow control ----------------
	// pipeline holds only when both buffer entries wait and nothing drains
	assign en       = (cnt_q != 2'd2) || out_ready;
	assign in_ready = en;
	assign push     = en && vld_q[PIPE_LAT-1];
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_window_q <= WIN_RESET;
		end else if (cfg_we) begin
			phase_window_q <= cfg_wdata;
		end
	end

	// ---------------- stage 1: sign and magnitude of time ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= days_after_epoch[31];
			mag_s1 <= days_after_epoch[31] ? (32'd0 - days_after_epoch) : days_after_epoch;
		end
	end

	// ---------------- stages 2..4: rate times time ----------------
	mpc_rate_mul #(.TIME_FRACTION_BITS(TIME_FRACTION_BITS), .RATE(SUN_G_RATE), .NEG(1'b0))
	u_rm_g (.clk(clk), .en(en), .mag(mag_s1), .neg(neg_s1), .prod(rg));

	mpc_rate_mul #(.TIME_FRACTION_BITS(TIME_FRACTION_BITS), .RATE(SUN_L_RATE), .NEG(1'b0))
	u_rm_l (.clk(clk), .en(en), .mag(mag_s1), .neg(neg_s1), .prod(rl));

	mpc_rate_mul #(.TIME_FRACTION_BITS(TIME_FRACTION_BITS), .RATE(MOON_L_RATE), .NEG(1'b0))
	u_rm_m (.clk(clk), .en(en), .mag(mag_s1), .neg(neg_s1), .prod(rm));

	for (genvar i = 0; i < MOON_N; i++) begin : g_moon_rate
		mpc_rate_mul #(
			.TIME_FRACTION_BITS(TIME_FRACTION_BITS),
			.RATE              (MOON_RATE[i]),
			.NEG               (MOON_RATE_NEG[i])
		) u_rm (.clk(clk), .en(en), .mag(mag_s1), .neg(neg_s1), .prod(rr[i]));
	end

	// ---------------- stage 5: sine arguments ----------------
	assign g = (SUN_G_BASE + rg) & ANGLE_MASK;

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s5[0] <= g;
			arg_s5[1] <= g << 1;
			for (int i = 0; i < MOON_N; i++) begin
				arg_s5[i+2] <= (MOON_BASE[i] + rr[i]) & ANGLE_MASK;
			end
			sunl_s5  <= SUN_L_BASE + rl;
			moonl_s5 <= MOON_L_BASE + rm;
		end
	end

	// ---------------- stages 6..28: eight sine lanes ----------------
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mpc_sine u_sine (
			.clk  (clk),
			.en   (en),
			.angle(arg_s5[i]),
			.mag  (smag[i]),
			.neg  (sneg[i])
		);
	end

	// linear terms ride alongside the sine lanes
	always_ff @(posedge clk) begin
		if (en) begin
			sunl_dly_q[0]  <= sunl_s5;
			moonl_dly_q[0] <= moonl_s5;
			for (int i = 1; i < SINE_LAT; i++) begin
				sunl_dly_q[i]  <= sunl_dly_q[i-1];
				moonl_dly_q[i] <= moonl_dly_q[i-1];
			end
		end
	end

	// ---------------- stage 29: amplitude times sine ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				term_s29[i] <= (sneg[i] ^ LANE_AMP_NEG[i])
					? (64'd0 - 64'(LANE_AMP[i]) * 64'(smag[i]))
					: (64'(LANE_AMP[i]) * 64'(smag[i]));
			end
			sunl_s29  <= sunl_dly_q[SINE_LAT-1];
			moonl_s29 <= moonl_dly_q[SINE_LAT-1];
		end
	end

	// ---------------- stages 30..32: adder tree ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s30   <= sunl_s29 + term_s29[0];
			sb_s30   <= term_s29[1];
			ma_s30   <= moonl_s29 + term_s29[2];
			mb_s30   <= term_s29[3] + term_s29[4];
			mc_s30   <= term_s29[5] + term_s29[6];
			md_s30   <= term_s29[7];
			sun_s31  <= (sa_s30 + sb_s30) & ANGLE_MASK;
			mab_s31  <= ma_s30 + mb_s30;
			mcd_s31  <= mc_s30 + md_s30;
			sun_s32  <= sun_s31;
			moon_s32 <= (mab_s31 + mcd_s31) & ANGLE_MASK;
		end
	end

	// ---------------- stage 33: phase angle ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s33     <= moon_s32 - sun_s32;
			sun32_s33  <= sun_s32[63:32];
			moon32_s33 <= moon_s32[63:32];
		end
	end

	// cosine as sine a quarter turn on: only the top two bits move
	assign cos_arg = {ph_s33[63:62] + 2'b01, ph_s33[61:0]};

	// ---------------- stages 34..56: cosine lane ----------------
	mpc_sine u_cos (
		.clk  (clk),
		.en   (en),
		.angle(cos_arg),
		.mag  (cmag),
		.neg  (cneg)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sun_dly_q[0]  <= sun32_s33;
			moon_dly_q[0] <= moon32_s33;
			ph_dly_q[0]   <= ph_s33[63:32];
			for (int i = 1; i < SINE_LAT; i++) begin
				sun_dly_q[i]  <= sun_dly_q[i-1];
				moon_dly_q[i] <= moon_dly_q[i-1];
				ph_dly_q[i]   <= ph_dly_q[i-1];
			end
		end
	end

	// ---------------- stage 57: 1 - cos, window distances ----------------
	always_comb begin
		// half turn is taken as +pi
		if (ph_dly_q[SINE_LAT-1] == 32'h8000_0000) begin
			ps = HALF;
		end else begin
			ps = 34'(signed'(ph_dly_q[SINE_LAT-1]));
		end
		pa1 = (ps > 34'sd0) ? (ps - HALF) : (ps + HALF);
		a0  = (ps < 34'sd0) ? 34'(-ps) : 34'(ps);
		a1  = (pa1 < 34'sd0) ? 34'(-pa1) : 34'(pa1);
		a2  = ((ps - QUART) < 34'sd0) ? 34'(QUART - ps) : 34'(ps - QUART);
		a3  = ((ps + QUART) < 34'sd0) ? 34'(-(ps + QUART)) : 34'(ps + QUART);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s57    <= cneg ? (Q30_ONE + 32'(cmag)) : (Q30_ONE - 32'(cmag));
			a0_s57   <= a0;
			a1_s57   <= a1;
			a2_s57   <= a2;
			a3_s57   <= a3;
			gtq_s57  <= ps > QUART;
			gt0_s57  <= ps > 34'sd0;
			gtmq_s57 <= ps > -QUART;
			sun_s57  <= sun_dly_q[SINE_LAT-1];
			moon_s57 <= moon_dly_q[SINE_LAT-1];
			ph_s57   <= ph_dly_q[SINE_LAT-1];
		end
	end

	// ---------------- stage 58: percent and class ----------------
	assign w        = 34'(phase_window_q);
	assign pct_full = 38'(c_s57) * 38'd50 + 38'(Q30_ONE >> 1);

	// classes tested in priority order; zero window never matches
	always_comb begin
		if (a0_s57 < w) begin
			kind = KIND_NEW;
		end else if (a1_s57 < w) begin
			kind = KIND_FULL;
		end else if (a2_s57 < w) begin
			kind = KIND_FIRST_Q;
		end else if (a3_s57 < w) begin
			kind = KIND_LAST_Q;
		end else if (gtq_s57) begin
			kind = KIND_WAX_GIB;
		end else if (gt0_s57) begin
			kind = KIND_WAX_CRES;
		end else if (gtmq_s57) begin
			kind = KIND_WANE_CRES;
		end else begin
			kind = KIND_WANE_GIB;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s58.sun   <= sun_s57;
			res_s58.moon  <= moon_s57;
			res_s58.phase <= ph_s57;
			res_s58.pct   <= pct_full[36:30];
			res_s58.kind  <= kind;
		end
	end

	// ---------------- two-word output buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					e0_q <= res_s58;
				end else begin
					e1_q <= res_s58;
				end
			end
			2'b01: begin
				e0_q <= e1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					e0_q <= res_s58;
				end else begin
					e0_q <= e1_q;
					e1_q <= res_s58;
				end
			end
			default: begin
				e0_q <= e0_q;
			end
		endcase
	end

	assign out_valid      = (cnt_q != 2'd0);
	assign sun_longitude  = signed'(e0_q.sun);
	assign moon_longitude = signed'(e0_q.moon);
	assign phase_angle    = signed'(e0_q.phase);
	assign percent_lit    = e0_q.pct;
	assign phase_kind     = e0_q.kind;

	// ---------------- checks ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd2) |-> pop)
		else $error("output buffer overrun");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("intake stalled without output backpressure");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (percent_lit <= 7'd100))
		else $error("percent lit above 100");

	a_new_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && phase_kind == KIND_NEW) |-> (phase_window_q != 31'd0))
		else $error("new moon class with zero window");

endmodule

// ===== tb/sv/tb_moon_phase_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moon_phase_calculator: self-checking bench for the moon phase calculator
// Drives day counts through the valid/ready input and checks every output
// word field by field against a bit-exact predictor of the almanac series.
// Runs under several phase window settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_moon_phase_calculator import mpc_pkg::*; ();

	localparam int          LIMIT      = 400000;  // cycles, far above a clean run
	localparam int          DRAIN      = 70;      // pipeline is 58 deep
	localparam int          N_DIRECTED = 18;
	localparam int          N_PHASES   = 6;
	localparam int          PER_PHASE  = 305;
	localparam logic [63:0] QTURN      = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ONE_Q30    = 64'h4000_0000;

	// idle patterns
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [31:0] sun;
		logic [31:0] moon;
		logic [31:0] phase;
		logic [6:0]  pct;
		phase_kind_t kind;
	} almanac_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [30:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] days_after_epoch = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] sun_longitude;
	logic signed [31:0] moon_longitude;
	logic signed [31:0] phase_angle;
	logic [6:0]         percent_lit;
	logic [2:0]         phase_kind;

	almanac_t   pending_words[$];
	logic [30:0] window_shadow = WIN_RESET;   // bench copy of phase_window
	idle_mode_t  idle_mode = IDLE_NONE;
	int          errors = 0;
	int          words_in = 0;
	int          words_out = 0;
	int          cycles = 0;

	always #1 clk = ~clk;

	moon_phase_calculator u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.days_after_epoch (days_after_epoch),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sun_longitude    (sun_longitude),
		.moon_longitude   (moon_longitude),
		.phase_angle      (phase_angle),
		.percent_lit      (percent_lit),
		.phase_kind       (phase_kind)
	);

	// ------------------------------------------------------------------
	// Predictor. Angles are 64-bit turn fractions; outputs take the top 32.
	// ------------------------------------------------------------------

	// floor(2^64 * num / den) mod 2^64
	function automatic logic [63:0] turn_frac(logic [63:0] num, logic [63:0] den);
		logic [127:0] q;
		q = {num % den, 64'd0} / {64'd0, den};
		return q[63:0];
	endfunction

	// rate times |days| >> 16, sign folded in mod 2^64
	function automatic logic [63:0] rate_by_days(logic [63:0] rate, bit rate_neg,
			logic [32:0] mag, bit t_neg);
		logic [127:0] prod;
		logic [63:0]  r;
		prod = {64'd0, rate} * {95'd0, mag};
		r = prod[79:16];
		if (rate_neg != t_neg) r = 64'd0 - r;
		return r;
	endfunction

	// Q30 sine through the folded Taylor chain
	function automatic longint sine_q30(logic [63:0] a);
		int unsigned dv [6] = '{156, 110, 72, 42, 20, 6};
		logic [63:0] f, x, x2, t, s;
		f = {2'b00, a[61:0]};
		if (a[62]) f = QTURN - f;
		x  = ((f >> 31) * {32'd0, PI_Q30}) >> 32;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		for (int i = 0; i < 6; i++)
			t = ONE_Q30 - ((x2 * t) >> 30) / dv[i];
		s = (x * t) >> 30;
		if (s > ONE_Q30) s = ONE_Q30;
		return a[63] ? -longint'(s) : longint'(s);
	endfunction

	function automatic logic [63:0] sine_contrib(logic [63:0] amp, bit amp_neg, longint s);
		logic [63:0] v;
		v = (amp >> 30) * ((s < 0) ? 64'(-s) : 64'(s));
		if ((s < 0) != amp_neg) v = 64'd0 - v;
		return v;
	endfunction

	function automatic longint mag64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic almanac_t predict_almanac(logic [31:0] raw, logic [30:0] win);
		int unsigned amp  [6] = '{629, 127, 66, 21, 19, 11};
		bit          aneg [6] = '{0, 1, 0, 0, 1, 1};
		int unsigned base [6] = '{1349, 2592, 2357, 2699, 3575, 1866};
		int unsigned rate [6] = '{47719885, 41333538, 89053423, 95439770, 3599905, 96640405};
		bit          rneg [6] = '{0, 1, 0, 0, 0, 0};
		almanac_t    r;
		bit          neg;
		logic [32:0] mag;
		logic [63:0] g, sun, moon, arg, ph, c;
		longint      p, w, hp, qp;
		neg = raw[31];
		mag = neg ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
		hp  = 64'sh8000_0000;
		qp  = 64'sh4000_0000;
		w   = longint'(win);

		g = (turn_frac(357528, 360000) +
			rate_by_days(turn_frac(9856003, 64'd3600000000), 0, mag, neg)) &
			64'hFFFF_FFFF_0000_0000;
		sun = turn_frac(280460, 360000) +
			rate_by_days(turn_frac(9856474, 64'd3600000000), 0, mag, neg);
		sun += sine_contrib(turn_frac(1915, 360000), 0, sine_q30(g));
		sun += sine_contrib(turn_frac(20, 360000), 0, sine_q30(g << 1));
		sun &= 64'hFFFF_FFFF_0000_0000;

		moon = turn_frac(21832, 36000) +
			rate_by_days(turn_frac(481267883, 64'd13149000000), 0, mag, neg);
		for (int i = 0; i < 6; i++) begin
			arg = (turn_frac(base[i], 3600) +
				rate_by_days(turn_frac(rate[i], 1314900000), rneg[i], mag, neg))
				& 64'hFFFF_FFFF_0000_0000;
			moon += sine_contrib(turn_frac(amp[i], 36000), aneg[i], sine_q30(arg));
		end
		moon &= 64'hFFFF_FFFF_0000_0000;

		ph = moon - sun;
		c  = ONE_Q30 - 64'(sine_q30(ph + QTURN));   // 0..2^31
		c  = (c * 50 + (ONE_Q30 >> 1)) >> 30;

		p = longint'($signed(ph[63:32]));
		if (p == -hp) p = hp;                       // half turn counts as +pi

		if (mag64(p) < w)                          r.kind = KIND_NEW;
		else if (mag64(p > 0 ? p - hp : p + hp) < w) r.kind = KIND_FULL;
		else if (mag64(p - qp) < w)                r.kind = KIND_FIRST_Q;
		else if (mag64(p + qp) < w)                r.kind = KIND_LAST_Q;
		else if (p > qp)                           r.kind = KIND_WAX_GIB;
		else if (p > 0)                            r.kind = KIND_WAX_CRES;
		else if (p > -qp)                          r.kind = KIND_WANE_CRES;
		else                                       r.kind = KIND_WANE_GIB;

		r.sun   = sun[63:32];
		r.moon  = moon[63:32];
		r.phase = ph[63:32];
		r.pct   = c[6:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall on out_ready, compare every accepted word
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		almanac_t e;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t: timeout, %0d words still pending", $time, pending_words.size());
			$display("tb_moon_phase_calculator: done, errors");
			$finish;
		end
		if (arst_n)
			out_ready <= (idle_mode == IDLE_RECV) ? ($urandom_range(99) >= 58) :
				(idle_mode == IDLE_BOTH) ? ($urandom_range(99) >= 24) : 1'b1;
		if (out_valid && out_ready) begin
			words_out++;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, sun %h moon %h", $time,
					sun_longitude, moon_longitude);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (sun_longitude !== e.sun) begin
					$display("%0t: sun_longitude exp %h got %h", $time, e.sun, sun_longitude);
					errors++;
				end
				if (moon_longitude !== e.moon) begin
					$display("%0t: moon_longitude exp %h got %h", $time, e.moon, moon_longitude);
					errors++;
				end
				if (phase_angle !== e.phase) begin
					$display("%0t: phase_angle exp %h got %h", $time, e.phase, phase_angle);
					errors++;
				end
				if (percent_lit !== e.pct) begin
					$display("%0t: percent_lit exp %0d got %0d", $time, e.pct, percent_lit);
					errors++;
				end
				if (phase_kind !== e.kind) begin
					$display("%0t: phase_kind exp %0d got %0d", $time, e.kind, phase_kind);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// present one word, with a random idle gap ahead of it in sender modes
	task automatic push_days(logic [31:0] d);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SEND) ? 58 : (idle_mode == IDLE_BOTH) ? 24 : 0;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct) @(posedge clk);
		end
		in_valid         <= 1'b1;
		days_after_epoch <= d;
		do @(posedge clk); while (!in_ready);
		pending_words.push_back(predict_almanac(d, window_shadow));
		words_in++;
	endtask

	// window may only change with the pipeline empty
	task automatic drain_and_set_window(logic [30:0] w);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_we        <= 1'b1;
		cfg_wdata     <= w;
		window_shadow  = w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// directed day counts: sign and magnitude extremes, whole days, epoch
	logic [31:0] directed_days [N_DIRECTED] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000,
		32'h001D_8800, 32'hFFE2_7800, 32'h0016_2000, 32'h0007_6000,
		32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000,
		32'hC000_0000, 32'h00FF_FF00
	};

	// windows per random phase: zero, a quarter turn, above range, default, then two drawn at random
	logic [30:0] phase_windows [N_PHASES] = '{
		31'd0, 31'h4000_0000, 31'h7FFF_FFFF, WIN_RESET, 31'd0, 31'd0
	};

	initial begin
		logic [31:0] d;
		int sel;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, reset window, then again at the window extremes
		idle_mode = IDLE_NONE;
		for (int i = 0; i < N_DIRECTED; i++) push_days(directed_days[i]);
		drain_and_set_window(31'd0);
		for (int i = 0; i < N_DIRECTED; i++) push_days(directed_days[i]);
		drain_and_set_window(31'h7FFF_FFFF);
		for (int i = 0; i < N_DIRECTED; i++) push_days(directed_days[i]);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == 4)
				phase_windows[ph] = 31'($urandom_range(32'h4000_0000));
			if (ph == 5)
				phase_windows[ph] = 31'($urandom_range(1000, 300000000));
			drain_and_set_window(phase_windows[ph]);
			idle_mode = idle_mode_t'(ph % 4);
			for (int i = 0; i < PER_PHASE; i++) begin
				sel = $urandom_range(9);
				// half full-range, some within 1200 days of the epoch, a few near the ends
				if (sel < 5)      d = $urandom;
				else if (sel < 9) d = 32'($signed($urandom_range(0, 32'h0960_0000))) -
						32'h04B0_0000;
				else              d = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255) :
						32'h8000_0000 + $urandom_range(255);
				push_days(d);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("run covered %0d words in, %0d out, over %0d window settings", words_in,
			words_out, N_PHASES + 3);
		$display("idle patterns: free flow, sender gaps, receiver stalls, both; %0d mismatches",
			errors);
		if (errors == 0) begin
			$display("tb_moon_phase_calculator: done, clean");
		end else begin
			$display("tb_moon_phase_calculator: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mpc_pkg.sv
rtl/mpc_rate_mul.sv
rtl/mpc_cell.sv
rtl/mpc_sine.sv
rtl/moon_phase_calculator.sv
tb/sv/tb_moon_phase_calculator.sv
